// ===== hdl/lsws_pkg.sv =====
package lsws_pkg;

   localparam int DEF_MAX_ELEMENTS = 1024;
   localparam int DEF_TABLE_SLOTS  = 2048;

   localparam int VALUE_W  = 16;
   localparam int TARGET_W = 32;
   localparam int START_W  = 10;
   localparam int LENGTH_W = 11;

   // hash: low 48 bits of key * golden-ratio constant, folded by 29
   localparam int          HASH_W       = 48;
   localparam int          HALF_W       = 24;
   localparam int          FOLD_SHIFT   = 29;
   localparam logic [23:0] HASH_MULT_LO = 24'h4A7C15;
   localparam logic [23:0] HASH_MULT_HI = 24'h79B97F;

   localparam int QUEUE_DEPTH = 4;

   function automatic int key_w(int max_el);
      int pw;
      pw = VALUE_W + $clog2(max_el) + 1;
      return ((pw > TARGET_W) ? pw : TARGET_W) + 1;
   endfunction

   function automatic int entry_w(int max_el, int slots);
      return 2 * key_w(max_el) + 2 * $clog2(slots) + $clog2(max_el) + 2;
   endfunction

endpackage

// ===== hdl/lsws_fifo.sv =====
module lsws_fifo import lsws_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW:0]      count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != (AW+1)'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/lsws_front.sv =====
module lsws_front import lsws_pkg::*; #(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   parameter int TABLE_SLOTS  = DEF_TABLE_SLOTS,
   parameter int EW           = entry_w(DEF_MAX_ELEMENTS, DEF_TABLE_SLOTS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [TARGET_W-1:0] target_sum,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [VALUE_W-1:0]  req_element_value,
   input  logic                       req_last_element,
   output logic                       q_valid,
   input  logic                       q_ready,
   output logic [EW-1:0]              q_data
);

   localparam int IW = $clog2(MAX_ELEMENTS);
   localparam int CW = IW + 1;
   localparam int PW = VALUE_W + IW + 1;
   localparam int KW = key_w(MAX_ELEMENTS);
   localparam int SW = $clog2(TABLE_SLOTS);

   typedef struct packed {
      logic [KW-1:0] key_ins;
      logic [SW-1:0] home_ins;
      logic [KW-1:0] key_look;
      logic [SW-1:0] home_look;
      logic [IW-1:0] idx;
      logic          in_cap;
      logic          last;
   } entry_type;

   typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_type;

   fstate_type            state_ff;
   logic signed [PW-1:0]  prefix_ff;
   logic [CW-1:0]         count_ff;
   entry_type             ent_ff;
   logic [1:0]            part_ff;
   logic                  second_ff;
   logic [HASH_W-1:0]     acc_ff;

   logic [KW-1:0]         hkey;
   logic [HASH_W-1:0]     hkey_ext;
   logic [HALF_W-1:0]     mul_x;
   logic [HALF_W-1:0]     mul_y;
   logic [HASH_W-1:0]     prod;
   logic [HASH_W-1:0]     acc_in;
   logic [HASH_W-1:0]     folded;
   logic signed [PW-1:0]  prefix_in;
   logic [KW-1:0]         key_ins_in;

   assign req_ready = (state_ff == F_IDLE);
   assign q_valid   = (state_ff == F_PUSH);
   assign q_data    = ent_ff;

   // one 24x24 multiplier, three partial products per key (mod 2^48)
   assign hkey     = second_ff ? ent_ff.key_look : ent_ff.key_ins;
   assign hkey_ext = {{(HASH_W-KW){hkey[KW-1]}}, hkey};
   assign mul_x    = (part_ff == 2'd2) ? hkey_ext[HASH_W-1:HALF_W] : hkey_ext[HALF_W-1:0];
   assign mul_y    = (part_ff == 2'd1) ? HASH_MULT_HI : HASH_MULT_LO;
   assign prod     = HASH_W'(mul_x * mul_y);
   assign acc_in   = (part_ff == 2'd0) ? prod
                                       : acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
   assign folded   = acc_in ^ (acc_in >> FOLD_SHIFT);

   assign prefix_in  = prefix_ff + {{(PW-VALUE_W){req_element_value[VALUE_W-1]}},
                                    req_element_value};
   assign key_ins_in = {{(KW-PW){prefix_ff[PW-1]}}, prefix_ff}
                     + {{(KW-TARGET_W){target_sum[TARGET_W-1]}}, target_sum};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         prefix_ff <= '0;
         count_ff  <= '0;
         part_ff   <= '0;
         second_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  ent_ff.last <= req_last_element;
                  part_ff     <= '0;
                  second_ff   <= 1'b0;
                  if (count_ff < CW'(MAX_ELEMENTS)) begin
                     ent_ff.key_ins  <= key_ins_in;
                     ent_ff.key_look <= {{(KW-PW){prefix_in[PW-1]}}, prefix_in};
                     ent_ff.idx      <= count_ff[IW-1:0];
                     ent_ff.in_cap   <= 1'b1;
                     prefix_ff       <= req_last_element ? '0 : prefix_in;
                     count_ff        <= req_last_element ? '0 : count_ff + 1'b1;
                     state_ff        <= F_HASH;
                  end else begin
                     ent_ff.in_cap <= 1'b0;
                     state_ff      <= F_PUSH;
                     if (req_last_element) begin
                        prefix_ff <= '0;
                        count_ff  <= '0;
                     end
                  end
               end
            end
            F_HASH: begin
               acc_ff <= acc_in;
               if (part_ff == 2'd2) begin
                  part_ff <= '0;
                  if (!second_ff) begin
                     ent_ff.home_ins <= folded[SW-1:0];
                     second_ff       <= 1'b1;
                  end else begin
                     ent_ff.home_look <= folded[SW-1:0];
                     state_ff         <= F_PUSH;
                  end
               end else begin
                  part_ff <= part_ff + 1'b1;
               end
            end
            F_PUSH: begin
               if (q_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/lsws_back.sv =====
module lsws_back import lsws_pkg::*; #(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   parameter int TABLE_SLOTS  = DEF_TABLE_SLOTS,
   parameter int EW           = entry_w(DEF_MAX_ELEMENTS, DEF_TABLE_SLOTS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  logic [EW-1:0]       q_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [START_W-1:0]  rsp_start_index,
   output logic [LENGTH_W-1:0] rsp_run_length,
   output logic                rsp_overflowed
);

   localparam int IW = $clog2(MAX_ELEMENTS);
   localparam int CW = IW + 1;
   localparam int KW = key_w(MAX_ELEMENTS);
   localparam int SW = $clog2(TABLE_SLOTS);

   typedef struct packed {
      logic [KW-1:0] key_ins;
      logic [SW-1:0] home_ins;
      logic [KW-1:0] key_look;
      logic [SW-1:0] home_look;
      logic [IW-1:0] idx;
      logic          in_cap;
      logic          last;
   } entry_type;

   typedef struct packed {
      logic          valid;
      logic [KW-1:0] key;
      logic [IW-1:0] first;
   } slot_type;

   typedef enum logic [2:0] {
      B_CLEAR, B_IDLE, B_INS_WAIT, B_INS_CMP, B_LK_WAIT, B_LK_CMP, B_FINISH
   } bstate_type;

   slot_type      slot_mem [TABLE_SLOTS];
   slot_type      rdata_ff;

   bstate_type    state_ff;
   entry_type     cur_ff;
   logic [SW-1:0] slot_ff;
   logic [SW-1:0] probes_ff;
   logic [CW-1:0] best_len_ff;
   logic [IW-1:0] best_start_ff;
   logic          cap_ff;
   logic          rsp_valid_ff;
   logic          found_ff;
   logic [START_W-1:0]  start_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic          over_ff;

   entry_type     q_entry;
   logic          mem_we;
   slot_type      mem_wdata;
   logic [KW-1:0] probe_key;
   logic          match;
   logic          stop;
   logic          exhausted;
   logic [CW-1:0] run_len;
   logic          rsp_load;

   assign q_ready = (state_ff == B_IDLE);
   assign q_entry = entry_type'(q_data);

   // slot_ff doubles as the sweep address while clearing
   assign mem_we    = (state_ff == B_CLEAR) || (state_ff == B_INS_CMP && !rdata_ff.valid);
   assign mem_wdata = (state_ff == B_CLEAR) ? slot_type'('0)
                                            : slot_type'({1'b1, cur_ff.key_ins, cur_ff.idx});

   assign probe_key = (state_ff == B_INS_CMP) ? cur_ff.key_ins : cur_ff.key_look;
   assign match     = rdata_ff.valid && (rdata_ff.key == probe_key);
   assign stop      = !rdata_ff.valid || match;
   assign exhausted = (probes_ff == SW'(TABLE_SLOTS-1));
   assign run_len   = CW'(cur_ff.idx) + 1'b1 - CW'(rdata_ff.first);
   assign rsp_load  = (state_ff == B_FINISH) && cur_ff.last && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_start_index = start_ff;
   assign rsp_run_length  = length_ff;
   assign rsp_overflowed  = over_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[slot_ff] <= mem_wdata;
      end
      rdata_ff <= slot_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         found_ff  <= (best_len_ff != '0);
         start_ff  <= START_W'(best_start_ff);
         length_ff <= LENGTH_W'(best_len_ff);
         over_ff   <= cap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_CLEAR;
         slot_ff       <= '0;
         probes_ff     <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
         cap_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_CLEAR: begin
               slot_ff <= slot_ff + 1'b1;
               if (slot_ff == SW'(TABLE_SLOTS-1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (q_valid) begin
                  cur_ff <= q_entry;
                  if (q_entry.in_cap) begin
                     slot_ff   <= q_entry.home_ins;
                     probes_ff <= '0;
                     state_ff  <= B_INS_WAIT;
                  end else begin
                     cap_ff   <= 1'b1;
                     state_ff <= B_FINISH;
                  end
               end
            end
            B_INS_WAIT: state_ff <= B_INS_CMP;
            B_INS_CMP: begin
               if (stop || exhausted) begin
                  slot_ff   <= cur_ff.home_look;
                  probes_ff <= '0;
                  state_ff  <= B_LK_WAIT;
               end else begin
                  slot_ff   <= slot_ff + 1'b1;
                  probes_ff <= probes_ff + 1'b1;
                  state_ff  <= B_INS_WAIT;
               end
            end
            B_LK_WAIT: state_ff <= B_LK_CMP;
            B_LK_CMP: begin
               if (match && (run_len > best_len_ff)) begin
                  best_len_ff   <= run_len;
                  best_start_ff <= rdata_ff.first;
               end
               if (stop || exhausted) begin
                  state_ff <= B_FINISH;
               end else begin
                  slot_ff   <= slot_ff + 1'b1;
                  probes_ff <= probes_ff + 1'b1;
                  state_ff  <= B_LK_WAIT;
               end
            end
            B_FINISH: begin
               if (!cur_ff.last) begin
                  state_ff <= B_IDLE;
               end else if (rsp_load) begin
                  best_len_ff   <= '0;
                  best_start_ff <= '0;
                  cap_ff        <= 1'b0;
                  slot_ff       <= '0;
                  state_ff      <= B_CLEAR;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   a_pop_starts_work: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> (state_ff == B_INS_WAIT) || (state_ff == B_FINISH))
      else $error("popped item did not start probing or finish");

   a_hit_sets_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_LK_CMP) && match && (run_len > best_len_ff) |=> best_len_ff != '0)
      else $error("lookup hit lost");

   a_result_then_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == B_CLEAR) && (slot_ff == '0))
      else $error("result not followed by table sweep");

endmodule

// ===== hdl/longest_subarray_with_sum_top.sv =====
// Channel   Direction  Signals                                      Accept
// req       in         req_element_value, req_last_element          req_valid && req_ready
// rsp       out        rsp_found, rsp_start_index, rsp_run_length,  rsp_valid && rsp_ready
//                      rsp_overflowed
// csr       in         csr_write_data (target_sum)                  csr_write_enable
//
// Front: accepts an item, hashes its two keys (three partial products each) on its single
//   24x24 multiplier unless over the cap, then pushes the entry; no new item until it is taken.
// Back: each table probe is a registered RAM read, then a compare, insert then lookup, with
//   dispatch before and finish after; it takes no new item until it is back in idle.
// After reset and after each last item the back sweeps all TABLE_SLOTS entries, one per
//   cycle, before taking the next item; items queue in front meanwhile (depth 4).
// Reset is synchronous, active high. A result waits in its output register; items keep
//   flowing while it is held, but the next last item stalls the back until the result is taken.
module longest_subarray_with_sum_top import lsws_pkg::*; #(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   parameter int TABLE_SLOTS  = DEF_TABLE_SLOTS   // power of two
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic signed [TARGET_W-1:0] csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [VALUE_W-1:0]  req_element_value,
   input  logic                       req_last_element,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic [START_W-1:0]         rsp_start_index,
   output logic [LENGTH_W-1:0]        rsp_run_length,
   output logic                       rsp_overflowed
);

   localparam int EW = entry_w(MAX_ELEMENTS, TABLE_SLOTS);

   logic signed [TARGET_W-1:0] target_ff;

   // front -> queue -> back
   logic          fq_valid;
   logic          fq_ready;
   logic [EW-1:0] fq_data;
   logic          qb_valid;
   logic          qb_ready;
   logic [EW-1:0] qb_data;

   // the user keeps target changes to idle periods; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_write_enable) begin
         target_ff <= csr_write_data;
      end
   end

   lsws_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .TABLE_SLOTS  (TABLE_SLOTS),
      .EW           (EW)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .target_sum        (target_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_element_value (req_element_value),
      .req_last_element  (req_last_element),
      .q_valid           (fq_valid),
      .q_ready           (fq_ready),
      .q_data            (fq_data)
   );

   lsws_fifo #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   lsws_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .TABLE_SLOTS  (TABLE_SLOTS),
      .EW           (EW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (qb_valid),
      .q_ready         (qb_ready),
      .q_data          (qb_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_start_index (rsp_start_index),
      .rsp_run_length  (rsp_run_length),
      .rsp_overflowed  (rsp_overflowed)
   );

endmodule
